### src/wpc_pkg.sv
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types, constants and helpers of the waypoint pursuit controller.
// ----------------------------------------------------------------------------
package wpc_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int WP_W        = 64;

    localparam int SQRT_STEPS   = 25;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 40;
    localparam int STEP_W       = 6;

    localparam logic signed [17:0] PI_Q12      = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [17:0] SIN_ONE     = 18'sd65536;
    localparam logic [23:0]        VEL_MAX     = 24'd8388607;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_ODOM = 1'b1;

    typedef enum logic [1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DIST_TOL   = 2'd2,
        REG_ANGLE_TOL  = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_PUSH,
        DP_LATCH,
        DP_DIFF,
        DP_SQX,
        DP_SQY,
        DP_SQRT,
        DP_CHECK,
        DP_ATAN_INIT,
        DP_ATAN,
        DP_WRAP_INIT,
        DP_WRAP,
        DP_VEL1,
        DP_VEL2,
        DP_SIN_INIT,
        DP_SIN,
        DP_MUL,
        DP_DIV,
        DP_DIV_END,
        DP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic step_last;
        logic queue_empty;
        logic queue_one;
        logic arrived;
        logic wrap_ok;
        logic dist_zero;
    } dp_status_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] dist_tolerance;
        logic [15:0] angle_tolerance;
    } cfg_t;

    function automatic logic [15:0] cordic_atan(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### src/wpc_ram.sv
// ----------------------------------------------------------------------------
// wpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/wpc_ctrl.sv
// ----------------------------------------------------------------------------
// wpc_ctrl
// Sequencer: steps the datapath through one odometry sample and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module wpc_ctrl
    import wpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       op,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_SQX, S_SQY, S_SQRT, S_CHK, S_ATI, S_AT, S_WI, S_WR,
        S_V1, S_V2, S_SI, S_SN, S_MU, S_DV, S_DE, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   pass1_reg, pass1_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        pass1_next     = pass1_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_PUSH)
                    begin
                        cmd.op = DP_PUSH;
                    end
                    else
                    begin
                        cmd.op     = DP_LATCH;
                        pass1_next = 1'b1;
                        state_next = status.queue_empty ? S_FIN : S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.op     = DP_DIFF;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.op     = DP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = DP_SQY;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = DP_SQRT;
                if (status.step_last)
                begin
                    state_next = pass1_reg ? S_CHK : S_ATI;
                end
            end
            S_CHK:
            begin
                // a newly exposed front waypoint is not checked again
                cmd.op     = DP_CHECK;
                pass1_next = 1'b0;
                if (status.arrived)
                begin
                    state_next = status.queue_one ? S_FIN : S_RD;
                end
                else
                begin
                    state_next = S_ATI;
                end
            end
            S_ATI:
            begin
                cmd.op     = DP_ATAN_INIT;
                state_next = S_AT;
            end
            S_AT:
            begin
                cmd.op = DP_ATAN;
                if (status.step_last)
                begin
                    state_next = S_WI;
                end
            end
            S_WI:
            begin
                cmd.op     = DP_WRAP_INIT;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (status.wrap_ok)
                begin
                    state_next = S_V1;
                end
                else
                begin
                    cmd.op = DP_WRAP;
                end
            end
            S_V1:
            begin
                cmd.op     = DP_VEL1;
                state_next = S_V2;
            end
            S_V2:
            begin
                cmd.op     = DP_VEL2;
                state_next = status.dist_zero ? S_FIN : S_SI;
            end
            S_SI:
            begin
                cmd.op     = DP_SIN_INIT;
                state_next = S_SN;
            end
            S_SN:
            begin
                cmd.op = DP_SIN;
                if (status.step_last)
                begin
                    state_next = S_MU;
                end
            end
            S_MU:
            begin
                cmd.op     = DP_MUL;
                state_next = S_DV;
            end
            S_DV:
            begin
                cmd.op = DP_DIV;
                if (status.step_last)
                begin
                    state_next = S_DE;
                end
            end
            S_DE:
            begin
                cmd.op     = DP_DIV_END;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = DP_LOAD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass1_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass1_reg     <= pass1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### src/wpc_dp.sv
// ----------------------------------------------------------------------------
// wpc_dp
// Datapath: waypoint queue, square root, CORDIC unit shared by atan2 and
// sine, PI speed law, divider and the result register.
// ----------------------------------------------------------------------------
module wpc_dp
    import wpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  cfg_t               cfg,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    output logic signed [23:0] lin_vel,
    output logic signed [23:0] ang_vel,
    output logic               waypoint_reached,
    output logic               path_done
);

    // queue state
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      accum_reg, accum_next;

    // working registers
    logic signed [23:0] px_reg, px_next, py_reg, py_next;
    logic signed [15:0] ph_reg, ph_next;
    logic signed [24:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [16:0]        dh_reg, dh_next;
    logic [48:0]        prod_reg, prod_next;
    logic [49:0]        rad_reg, rad_next;
    logic [27:0]        rem_reg, rem_next;
    logic [24:0]        dist_reg, dist_next;
    logic signed [43:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [19:0] cz_reg, cz_next;
    logic signed [17:0] bear_reg, bear_next;
    logic [23:0]        vel_reg, vel_next;
    logic [39:0]        num_reg, num_next;
    logic               neg_reg, neg_next;
    logic signed [23:0] angv_reg, angv_next;
    logic               reached_reg, reached_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;

    logic signed [23:0] lin_out_reg, lin_out_next, ang_out_reg, ang_out_next;
    logic               reach_out_reg, reach_out_next, done_out_reg, done_out_next;

    // memory port
    logic             ram_we;
    logic [PTR_W-1:0] ram_raddr;
    logic [WP_W-1:0]  ram_rdata;

    // combinational helpers
    logic signed [24:0] gx, gy;
    logic signed [16:0] hdiff;
    logic signed [49:0] sq;
    logic [27:0]        rem_sh, trial;
    logic [32:0]        acc_sum;
    logic signed [43:0] x0, y0, xs, ys;
    logic [3:0]         idx;
    logic signed [19:0] tab, zr;
    logic [48:0]        vel_sum;
    logic [36:0]        vel_sh;
    logic signed [17:0] bfold, s_val;
    logic signed [24:0] vs;
    logic signed [42:0] prod_s;
    logic [42:0]        mag;
    logic [28:0]        drem_sh, ddiv;

    wpc_ram #(
        .WIDTH (WP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata ({heading, pos_y, pos_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = (cmd.op == DP_CHECK) ? ptr_inc(rptr_reg) : rptr_reg;
    assign idx       = 4'(CORDIC_STEPS - 1) - cnt_reg[3:0];
    assign xs        = cx_reg >>> idx;
    assign ys        = cy_reg >>> idx;
    assign tab       = signed'({4'b0, cordic_atan(idx)});

    always_comb
    begin
        rptr_next      = rptr_reg;
        wptr_next      = wptr_reg;
        count_next     = count_reg;
        accum_next     = accum_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ph_next        = ph_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dh_next        = dh_reg;
        prod_next      = prod_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        dist_next      = dist_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        bear_next      = bear_reg;
        vel_next       = vel_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        angv_next      = angv_reg;
        reached_next   = reached_reg;
        cnt_next       = cnt_reg;
        lin_out_next   = lin_out_reg;
        ang_out_next   = ang_out_reg;
        reach_out_next = reach_out_reg;
        done_out_next  = done_out_reg;
        ram_we         = 1'b0;

        gx      = {ram_rdata[23], ram_rdata[23:0]};
        gy      = {ram_rdata[47], ram_rdata[47:24]};
        hdiff   = {ram_rdata[63], ram_rdata[63:48]} - {ph_reg[15], ph_reg};
        sq      = '0;
        rem_sh  = {rem_reg[25:0], rad_reg[49:48]};
        trial   = {1'b0, dist_reg, 2'b01};
        acc_sum = {1'b0, accum_reg} + 33'(dist_reg);
        x0      = {{3{dx_reg[24]}}, dx_reg, 16'b0};
        y0      = {{3{dy_reg[24]}}, dy_reg, 16'b0};
        zr      = cz_reg + 20'sd8;
        vel_sum = prod_reg + 49'(cfg.integ_gain) * 49'(accum_reg);
        vel_sh  = vel_sum[48:12];
        bfold   = bear_reg;
        s_val   = 18'(cy_reg);
        vs      = signed'({1'b0, vel_reg});
        prod_s  = '0;
        mag     = '0;
        drem_sh = {rem_reg, num_reg[39]};
        ddiv    = {1'b0, dist_reg, 3'b0};

        case (cmd.op)
            DP_PUSH:
            begin
                // drop the waypoint when the queue is full
                if (count_reg != CNT_W'(QUEUE_DEPTH))
                begin
                    ram_we     = 1'b1;
                    wptr_next  = ptr_inc(wptr_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            DP_LATCH:
            begin
                px_next      = pos_x;
                py_next      = pos_y;
                ph_next      = heading;
                reached_next = 1'b0;
                vel_next     = '0;
                angv_next    = '0;
            end
            DP_DIFF:
            begin
                dx_next = gx - {px_reg[23], px_reg};
                dy_next = gy - {py_reg[23], py_reg};
                dh_next = hdiff[16] ? 17'(-hdiff) : 17'(hdiff);
            end
            DP_SQX:
            begin
                sq        = dx_reg * dx_reg;
                prod_next = sq[48:0];
            end
            DP_SQY:
            begin
                sq        = dy_reg * dy_reg;
                rad_next  = {1'b0, prod_reg} + {1'b0, sq[48:0]};
                rem_next  = '0;
                dist_next = '0;
                cnt_next  = STEP_W'(SQRT_STEPS - 1);
            end
            DP_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    dist_next = {dist_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    dist_next = {dist_reg[23:0], 1'b0};
                end
                rad_next = {rad_reg[47:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
            end
            DP_CHECK:
            begin
                if (status.arrived)
                begin
                    rptr_next    = ptr_inc(rptr_reg);
                    count_next   = count_reg - 1'b1;
                    accum_next   = '0;
                    reached_next = 1'b1;
                end
            end
            DP_ATAN_INIT:
            begin
                accum_next = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                // pre-rotate the left half plane by a quarter turn
                if (dx_reg[24])
                begin
                    if (!dy_reg[24])
                    begin
                        cx_next = y0;
                        cy_next = -x0;
                        cz_next = HALF_PI_Q16;
                    end
                    else
                    begin
                        cx_next = -y0;
                        cy_next = x0;
                        cz_next = -HALF_PI_Q16;
                    end
                end
                else
                begin
                    cx_next = x0;
                    cy_next = y0;
                    cz_next = '0;
                end
                cnt_next = STEP_W'(CORDIC_STEPS - 1);
            end
            DP_ATAN:
            begin
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + tab;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - tab;
                end
                cnt_next = cnt_reg - 1'b1;
            end
            DP_WRAP_INIT:
            begin
                bear_next = 18'(zr >>> 4) - {{2{ph_reg[15]}}, ph_reg};
            end
            DP_WRAP:
            begin
                if (bear_reg > PI_Q12)
                begin
                    bear_next = bear_reg - TWO_PI_Q12;
                end
                else
                begin
                    bear_next = bear_reg + TWO_PI_Q12;
                end
            end
            DP_VEL1:
            begin
                prod_next = 49'(cfg.prop_gain) * 49'(dist_reg);
            end
            DP_VEL2:
            begin
                vel_next = (vel_sh > 37'(VEL_MAX)) ? VEL_MAX : vel_sh[23:0];
            end
            DP_SIN_INIT:
            begin
                // fold into the right half plane
                if (bear_reg > HALF_PI_Q12)
                begin
                    bfold = PI_Q12 - bear_reg;
                end
                else if (bear_reg < -HALF_PI_Q12)
                begin
                    bfold = -PI_Q12 - bear_reg;
                end
                cz_next  = 20'({bfold, 4'b0});
                cx_next  = 44'(CORDIC_GAIN);
                cy_next  = '0;
                cnt_next = STEP_W'(CORDIC_STEPS - 1);
            end
            DP_SIN:
            begin
                if (cz_reg >= 0)
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - tab;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + tab;
                end
                cnt_next = cnt_reg - 1'b1;
            end
            DP_MUL:
            begin
                if (cy_reg > 44'(SIN_ONE))
                begin
                    s_val = SIN_ONE;
                end
                else if (cy_reg < -44'(SIN_ONE))
                begin
                    s_val = -SIN_ONE;
                end
                prod_s   = s_val * vs;
                neg_next = prod_s[42];
                mag      = prod_s[42] ? 43'(-prod_s) : 43'(prod_s);
                num_next = mag[39:0];
                rem_next = '0;
                cnt_next = STEP_W'(DIV_STEPS - 1);
            end
            DP_DIV:
            begin
                if (drem_sh >= ddiv)
                begin
                    rem_next = 28'(drem_sh - ddiv);
                    num_next = {num_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_next = drem_sh[27:0];
                    num_next = {num_reg[38:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            DP_DIV_END:
            begin
                if (neg_reg)
                begin
                    angv_next = (num_reg > 40'd8388608) ? 24'sh800000
                                                        : -signed'(num_reg[23:0]);
                end
                else
                begin
                    angv_next = (num_reg > 40'(VEL_MAX)) ? signed'(VEL_MAX)
                                                         : signed'(num_reg[23:0]);
                end
            end
            DP_LOAD_OUT:
            begin
                lin_out_next   = signed'(vel_reg);
                ang_out_next   = angv_reg;
                reach_out_next = reached_reg;
                done_out_next  = (count_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    assign status.step_last   = (cnt_reg == '0);
    assign status.queue_empty = (count_reg == '0);
    assign status.queue_one   = (count_reg == CNT_W'(1));
    assign status.arrived     = (dist_reg < 25'(cfg.dist_tolerance))
                             && (dh_reg < 17'(cfg.angle_tolerance));
    assign status.wrap_ok     = !(bear_reg > PI_Q12) && !(bear_reg < -PI_Q12);
    assign status.dist_zero   = (dist_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            count_reg <= '0;
            accum_reg <= '0;
        end
        else
        begin
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        ph_reg        <= ph_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        dh_reg        <= dh_next;
        prod_reg      <= prod_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        dist_reg      <= dist_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        bear_reg      <= bear_next;
        vel_reg       <= vel_next;
        num_reg       <= num_next;
        neg_reg       <= neg_next;
        angv_reg      <= angv_next;
        reached_reg   <= reached_next;
        cnt_reg       <= cnt_next;
        lin_out_reg   <= lin_out_next;
        ang_out_reg   <= ang_out_next;
        reach_out_reg <= reach_out_next;
        done_out_reg  <= done_out_next;
    end

    assign lin_vel          = lin_out_reg;
    assign ang_vel          = ang_out_reg;
    assign waypoint_reached = reach_out_reg;
    assign path_done        = done_out_reg;

endmodule

### src/waypoint_pursuit_controller.sv
// ----------------------------------------------------------------------------
// waypoint_pursuit_controller
// Pure-pursuit path tracking with a PI speed law, in fixed point.
// ----------------------------------------------------------------------------
// A waypoint transfer (op = 0) is stored, or dropped when the 64-entry queue
// is full; it produces no result. An odometry transfer (op = 1) produces one
// result and keeps the input stalled until that result is loaded into the
// output register. The stall grows with each full-turn wrap of the bearing (at
// most two) and when a waypoint is reached and the next one must be measured;
// it is shorter when the last waypoint is reached and shortest with an empty
// queue. The time is set by the 25-step square root (run once per front
// waypoint looked at), the 16-step CORDIC unit used for atan2 and again for the
// sine, and the 40-step divider for the angular rate. A finished result waits
// in the output register while the next transfer is taken; a sample that
// finishes while that register is still held stalls until the result there has
// gone. The queue memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module waypoint_pursuit_controller
    import wpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] lin_vel,
    output logic signed [23:0] ang_vel,
    output logic               waypoint_reached,
    output logic               path_done
);

    cfg_t       cfg_reg, cfg_next;
    dp_cmd_t    cmd;
    dp_status_t status;
    reg_idx_t   sel;

    assign sel    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (sel)
                REG_PROP_GAIN:  cfg_next.prop_gain       = pwdata[15:0];
                REG_INTEG_GAIN: cfg_next.integ_gain      = pwdata[15:0];
                REG_DIST_TOL:   cfg_next.dist_tolerance  = pwdata[15:0];
                REG_ANGLE_TOL:  cfg_next.angle_tolerance = pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_PROP_GAIN:  prdata = {16'b0, cfg_reg.prop_gain};
            REG_INTEG_GAIN: prdata = {16'b0, cfg_reg.integ_gain};
            REG_DIST_TOL:   prdata = {16'b0, cfg_reg.dist_tolerance};
            REG_ANGLE_TOL:  prdata = {16'b0, cfg_reg.angle_tolerance};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= 16'd4096;
            cfg_reg.integ_gain      <= 16'd246;
            cfg_reg.dist_tolerance  <= 16'd82;
            cfg_reg.angle_tolerance <= 16'd410;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wpc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg_reg),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .heading          (heading),
        .lin_vel          (lin_vel),
        .ang_vel          (ang_vel),
        .waypoint_reached (waypoint_reached),
        .path_done        (path_done)
    );

endmodule

### src/wpc_checker.sv
// ----------------------------------------------------------------------------
// wpc_checker
// Port-level checks of the waypoint pursuit controller, bound to the top.
// ----------------------------------------------------------------------------
module wpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        op,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] lin_vel,
    input logic [23:0] ang_vel,
    input logic        waypoint_reached,
    input logic        path_done
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lin_vel) && $stable(ang_vel)
            && $stable(waypoint_reached) && $stable(path_done))
        else $error("result changed while stalled");

    // an empty queue commands a stop
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_done |-> lin_vel == 24'd0 && ang_vel == 24'd0)
        else $error("non-zero command with path done");

    a_vel_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !lin_vel[23])
        else $error("negative forward velocity");

    // a sample keeps the input stalled while it is worked on
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op |=> in_stall)
        else $error("input taken during a sample");

endmodule

bind waypoint_pursuit_controller wpc_checker u_wpc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .lin_vel          (lin_vel),
    .ang_vel          (ang_vel),
    .waypoint_reached (waypoint_reached),
    .path_done        (path_done)
);

### tb/sv/wpc_checker.sv
// ----------------------------------------------------------------------------
// wpc_predictor
// Watches the configuration port and both channels of the waypoint pursuit
// controller, predicts each odometry result and compares it field by field.
// ----------------------------------------------------------------------------
module wpc_predictor
    import wpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               op,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [23:0] lin_vel,
    input  logic signed [23:0] ang_vel,
    input  logic               waypoint_reached,
    input  logic               path_done,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count,
    output int                 arrival_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] h;
    } waypoint_t;

    typedef struct {
        logic [23:0] lin;
        logic [23:0] ang;
        logic        reached;
        logic        done;
    } command_t;

    localparam longint TURN_ANGLE [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2};

    cfg_t        gains;
    waypoint_t   route [QUEUE_DEPTH];
    int          head_ptr, tail_ptr, occupancy;
    logic [31:0] dist_sum;
    command_t    commands_due [$];

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, angle rounded half up from Q.16 to Q4.12
    function automatic longint direction_q12(input longint dy, input longint dx);
        longint x, y, z, t, nx, ny;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 102944;
            end
            else
            begin
                x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += TURN_ANGLE[i];
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= TURN_ANGLE[i];
            end
            x = nx; y = ny;
        end
        return (z + 8) >>> 4;
    endfunction

    function automatic longint sine_q16(input longint b);
        longint x, y, z, nx, ny;
        x = 39797;
        y = 0;
        if (b > 6434) b = 12868 - b;
        else if (b < -6434) b = -12868 - b;
        z = b * 16;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= TURN_ANGLE[i];
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += TURN_ANGLE[i];
            end
            x = nx; y = ny;
        end
        if (y > 65536) y = 65536;
        if (y < -65536) y = -65536;
        return y;
    endfunction

    function automatic longint unsigned range_to(input waypoint_t w, input longint px,
                                                  input longint py);
        longint dx, dy;
        dx = longint'(w.x) - px;
        dy = longint'(w.y) - py;
        return root_floor(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    task automatic track_odometry(input longint px, input longint py, input longint ph);
        command_t        c;
        waypoint_t       w;
        longint          dh, bearing, vel, angv, dx, dy;
        longint unsigned span, acc;
        c.reached = 1'b0;
        vel = 0;
        angv = 0;
        if (occupancy != 0)
        begin
            w = route[head_ptr];
            dh = longint'(w.h) - ph;
            if (dh < 0) dh = -dh;
            span = range_to(w, px, py);
            if (span < gains.dist_tolerance && dh < longint'(gains.angle_tolerance))
            begin
                head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
                occupancy--;
                dist_sum = '0;
                c.reached = 1'b1;
                arrival_count++;
            end
        end
        c.done = (occupancy == 0);
        if (occupancy != 0)
        begin
            w = route[head_ptr];
            dx = longint'(w.x) - px;
            dy = longint'(w.y) - py;
            span = range_to(w, px, py);
            bearing = direction_q12(dy, dx) - ph;
            while (bearing > 12868) bearing -= 25736;
            while (bearing < -12868) bearing += 25736;
            acc = longint'(dist_sum) + span;
            dist_sum = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            acc = (longint'(gains.prop_gain) * span
                   + longint'(gains.integ_gain) * longint'(dist_sum)) >> 12;
            vel = (acc > 8388607) ? 8388607 : longint'(acc);
            if (span != 0)
            begin
                angv = (sine_q16(bearing) * vel) / (longint'(span) * 8);
                if (angv > 8388607) angv = 8388607;
                if (angv < -8388608) angv = -8388608;
            end
        end
        c.lin = vel[23:0];
        c.ang = angv[23:0];
        commands_due.push_back(c);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        command_t want;
        if (!rst_n)
        begin
            gains = '{prop_gain: 16'd4096, integ_gain: 16'd246, dist_tolerance: 16'd82,
                      angle_tolerance: 16'd410};
            head_ptr = 0;
            tail_ptr = 0;
            occupancy = 0;
            dist_sum = '0;
            commands_due.delete();
            pending = 0;
            fail_count = 0;
            result_count = 0;
            arrival_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_PROP_GAIN:  gains.prop_gain       = pwdata[15:0];
                    REG_INTEG_GAIN: gains.integ_gain      = pwdata[15:0];
                    REG_DIST_TOL:   gains.dist_tolerance  = pwdata[15:0];
                    REG_ANGLE_TOL:  gains.angle_tolerance = pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (op == OP_PUSH)
                begin
                    // drop the waypoint when the queue is full
                    if (occupancy < QUEUE_DEPTH)
                    begin
                        route[tail_ptr] = '{x: pos_x, y: pos_y, h: heading};
                        tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
                        occupancy++;
                    end
                end
                else
                begin
                    track_odometry(pos_x, pos_y, heading);
                end
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (commands_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: exp none, got lin %0d ang %0d",
                                 lin_vel, ang_vel);
                end
                else
                begin
                    want = commands_due.pop_front();
                    if (want.lin !== lin_vel || want.ang !== ang_vel
                        || want.reached !== waypoint_reached || want.done !== path_done)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp lin %0d ang %0d reached %0b done %0b,",
                                      " got lin %0d ang %0d reached %0b done %0b"},
                                     $signed(want.lin), $signed(want.ang), want.reached,
                                     want.done, lin_vel, ang_vel, waypoint_reached,
                                     path_done);
                    end
                end
            end
            pending = commands_due.size();
        end
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the waypoint pursuit controller: directed corner
// cases, then random waypoint/odometry episodes under several gain settings,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import wpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 6000;
    localparam int SETTLE      = 300;

    logic               clk, rst_n;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               in_valid, in_stall, op;
    logic signed [23:0] pos_x, pos_y;
    logic signed [15:0] heading;
    logic               out_valid, out_stall;
    logic signed [23:0] lin_vel, ang_vel;
    logic               waypoint_reached, path_done;
    int                 fail_count, pending, result_count, arrival_count;

    int        send_gap_max, recv_gap_max, item_count, quiet;
    bit        long_hold;
    logic [15:0] tol_dist, tol_angle;
    logic [63:0] route_copy [$];

    waypoint_pursuit_controller dut (.*);
    wpc_predictor u_predictor (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall before each transfer, one long hold on request
    initial
    begin
        int n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = long_hold ? 400 : $urandom_range(recv_gap_max, 0);
            long_hold = 1'b0;
            repeat (n) @(negedge clk) out_stall <= 1'b1;
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [15:0] v);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {16'h0, v};
        @(negedge clk) penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_DIST_TOL) tol_dist = v;
        if (idx == REG_ANGLE_TOL) tol_angle = v;
    endtask

    task automatic transfer(input logic o, input logic [23:0] x, input logic [23:0] y,
                            input logic [15:0] h);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid <= 1'b1; op <= o; pos_x <= x; pos_y <= y; heading <= h;
        do @(posedge clk); while (in_stall);
        item_count++;
        if (o == OP_PUSH)
        begin
            if (route_copy.size() < QUEUE_DEPTH) route_copy.push_back({h, y, x});
        end
        else if (route_copy.size() != 0 && route_copy[0] == {h, y, x}
                 && tol_dist != 0 && tol_angle != 0)
        begin
            route_copy.pop_front();
        end
    endtask

    task automatic drain_and_idle();
        @(negedge clk) in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] pg, input logic [15:0] ig,
                             input logic [15:0] dt, input logic [15:0] at);
        drain_and_idle();
        reg_write(REG_PROP_GAIN, pg);
        reg_write(REG_INTEG_GAIN, ig);
        reg_write(REG_DIST_TOL, dt);
        reg_write(REG_ANGLE_TOL, at);
    endtask

    initial
    begin
        logic [23:0] bx, by, wx, wy;
        logic [15:0] wh;
        int          k, phase;
        bit          held, paused;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; op = OP_PUSH; pos_x = '0; pos_y = '0; heading = '0;
        send_gap_max = 3; recv_gap_max = 3; item_count = 0;
        long_hold = 1'b0; tol_dist = 16'd82; tol_angle = 16'd410;
        held = 1'b0; paused = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // empty queue, field extremes, arrival to the next and to an empty queue
        transfer(OP_ODOM, 24'h0, 24'h0, 16'h0);
        transfer(OP_PUSH, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
        transfer(OP_PUSH, 24'h800000, 24'h800000, 16'h8000);
        transfer(OP_ODOM, 24'h800000, 24'h800000, 16'h8000);
        transfer(OP_ODOM, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);
        transfer(OP_ODOM, 24'h7FFFFF, 24'h800000, 16'h0);
        transfer(OP_ODOM, 24'h800000, 24'h800000, 16'h8000);
        // zero distance but heading outside tolerance
        transfer(OP_PUSH, 24'h0, 24'h0, 16'h0);
        transfer(OP_ODOM, 24'h0, 24'h0, 16'd20000);
        transfer(OP_ODOM, 24'h001000, 24'hFFF000, 16'h8000);
        transfer(OP_ODOM, 24'hFFF000, 24'h001000, 16'h7FFF);
        transfer(OP_ODOM, 24'h0, 24'h0, 16'h0);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        transfer(OP_PUSH, 24'h7FFFFF, 24'h800000, 16'h1234);
        transfer(OP_ODOM, 24'h800000, 24'h7FFFFF, 16'h8000);
        transfer(OP_ODOM, 24'h800000, 24'h7FFFFF, 16'h8000);

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: configure(16'd4096, 16'd246, 16'd82, 16'd410);
                1: configure(16'h0, 16'h0, 16'h0, 16'h0);
                2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: configure(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
            endcase
            send_gap_max = (phase == 2) ? 0 : 17;
            recv_gap_max = (phase == 4) ? 0 : 17;
            while (item_count < 72 * (phase + 1) + 16)
            begin
                k = $urandom_range(99, 0);
                if (k < 5)
                begin
                    // flood the queue past full
                    repeat (70)
                        transfer(OP_PUSH, 24'($urandom), 24'($urandom), 16'($urandom));
                end
                else if (k < 25)
                begin
                    transfer(1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
                end
                else
                begin
                    bx = 24'($urandom_range(32'h1FFFFF, 0) - 32'h100000);
                    by = 24'($urandom_range(32'h1FFFFF, 0) - 32'h100000);
                    repeat ($urandom_range(5, 1))
                        transfer(OP_PUSH, bx + 24'($urandom_range(32768, 0)) - 24'd16384,
                                 by + 24'($urandom_range(32768, 0)) - 24'd16384,
                                 16'($urandom_range(16384, 0)) - 16'd8192);
                    repeat ($urandom_range(8, 2))
                    begin
                        if (route_copy.size() != 0 && $urandom_range(9, 0) < 4)
                        begin
                            {wh, wy, wx} = route_copy[0];
                            transfer(OP_ODOM, wx, wy, wh);
                        end
                        else
                        begin
                            transfer(OP_ODOM, bx + 24'($urandom_range(65535, 0)) - 24'd32768,
                                     by + 24'($urandom_range(65535, 0)) - 24'd32768,
                                     16'($urandom));
                        end
                    end
                end
                if (phase == 1 && !held)
                begin
                    long_hold = 1'b1;
                    held = 1'b1;
                end
                if (phase == 3 && item_count > 260 && !paused)
                begin
                    @(negedge clk) in_valid <= 1'b0;
                    wait (pending == 0);
                    paused = 1'b1;
                end
            end
        end

        drain_and_idle();
        $display("%0d items, %0d results, %0d waypoints reached, six gain settings",
                 item_count, result_count, arrival_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
